FILE: hw/rtl/escape_tagged_uart_demux_assert.svh
// Assertion macros for the escape-tagged UART demux checker.
`ifndef ESCAPE_TAGGED_UART_DEMUX_ASSERT_SVH
`define ESCAPE_TAGGED_UART_DEMUX_ASSERT_SVH

// Clocked assertion, ignored while reset is held.
`define ETUD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked across reset.
`define ETUD_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/etud_pkg.sv
// Shared types, constants and helpers of the escape-tagged UART demux.
package etud_pkg;

    localparam int TAG_COUNT     = 15;
    localparam int TAG_TABLE_LEN = 15;
    localparam int TAG_LIMIT     = (TAG_COUNT < TAG_TABLE_LEN) ? TAG_COUNT : TAG_TABLE_LEN;
    localparam int ADDR_W        = 5;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = 2;
    localparam int Q_CNT_W       = 3;

    localparam logic [3:0] RAW_CHANNEL = 4'd15;
    localparam logic [3:0] MAX_DEFAULT = 4'd14;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_CR       = 8'h0d;

    localparam logic [7:0] TAG_CODES [TAG_TABLE_LEN] = '{
        8'he1, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8,
        8'hea, 8'heb, 8'hec, 8'hed, 8'hef, 8'hf0, 8'he9
    };

    typedef enum logic [2:0] {
        REG_ESC_START  = 3'd0,
        REG_ESC_ESC    = 3'd1,
        REG_RESET_SEL  = 3'd2,
        REG_PATCH_EN   = 3'd3,
        REG_DEFAULT_CH = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] escape_start_byte;
        logic [7:0] escaped_escape_byte;
        logic [7:0] reset_select_byte;
        logic       patch_enable;
        logic [3:0] default_channel;
    } cfg_t;

    // One input byte's worth of output, expanded by the back end.
    typedef struct packed {
        logic       raw_ins;
        logic [7:0] raw_ins_byte;
        logic [7:0] raw_byte;
        logic       guest_ins;
        logic [7:0] guest_ins_byte;
        logic       guest_en;
        logic [3:0] guest_chan;
        logic [7:0] guest_byte;
    } cmd_t;

    typedef struct packed {
        logic       ins;
        logic [7:0] ins_byte;
        logic       cr_next;
        logic       lf_next;
    } patch_t;

    // CR/LF pair completion for one byte on one channel.
    function automatic patch_t patch_step(logic cr, logic lf, logic [7:0] b);
        patch_t p;
        p.ins      = 1'b0;
        p.ins_byte = CH_CR;
        p.cr_next  = cr;
        p.lf_next  = lf;
        if (b == CH_LF) begin
            p.lf_next = 1'b1;
        end else if (b == CH_CR) begin
            p.cr_next = 1'b1;
        end else begin
            p.ins      = cr | lf;
            p.ins_byte = cr ? CH_LF : CH_CR;
            p.cr_next  = 1'b0;
            p.lf_next  = 1'b0;
        end
        if (p.cr_next && p.lf_next) begin
            p.cr_next = 1'b0;
            p.lf_next = 1'b0;
        end
        return p;
    endfunction

endpackage

FILE: hw/rtl/etud_front.sv
// Front end: escape decode, channel select and line-ending patch state.
module etud_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  etud_pkg::cfg_t cfg,
    input  logic          in_valid,
    input  logic [7:0]    in_byte,
    input  logic          q_full,
    output logic          in_ready,
    output logic          push,
    output etud_pkg::cmd_t cmd
);
    import etud_pkg::*;

    logic        esc_reg, esc_next;
    logic [3:0]  chan_reg, chan_next;
    logic [15:0] cr_reg, cr_next;
    logic [15:0] lf_reg, lf_next;
    logic        to_guest;
    logic [7:0]  gdata;
    logic        tag_hit;
    logic [3:0]  tag_ch;
    patch_t      praw, pguest;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb begin
        tag_hit = 1'b0;
        tag_ch  = 4'd0;
        for (int i = 0; i < TAG_LIMIT; i++) begin
            if (!tag_hit && in_byte == TAG_CODES[i]) begin
                tag_hit = 1'b1;
                tag_ch  = 4'(i);
            end
        end
    end

    always_comb begin
        esc_next  = esc_reg;
        chan_next = chan_reg;
        to_guest  = 1'b0;
        gdata     = in_byte;
        if (esc_reg) begin
            esc_next = 1'b0;
            if (in_byte == cfg.escaped_escape_byte) begin
                gdata    = cfg.escape_start_byte;
                to_guest = 1'b1;
            end else if (in_byte == cfg.reset_select_byte) begin
                chan_next = (cfg.default_channel > MAX_DEFAULT) ? MAX_DEFAULT
                                                                : cfg.default_channel;
            end else if (tag_hit) begin
                chan_next = tag_ch;
            end
        end else if (in_byte == cfg.escape_start_byte) begin
            esc_next = 1'b1;
        end else begin
            to_guest = 1'b1;
        end
    end

    // Raw is always channel 15 and the guest never is, so the two don't interact.
    assign praw   = patch_step(cr_reg[RAW_CHANNEL], lf_reg[RAW_CHANNEL], in_byte);
    assign pguest = patch_step(cr_reg[chan_reg], lf_reg[chan_reg], gdata);

    always_comb begin
        cr_next = cr_reg;
        lf_next = lf_reg;
        if (cfg.patch_enable) begin
            cr_next[RAW_CHANNEL] = praw.cr_next;
            lf_next[RAW_CHANNEL] = praw.lf_next;
            if (to_guest) begin
                cr_next[chan_reg] = pguest.cr_next;
                lf_next[chan_reg] = pguest.lf_next;
            end
        end
    end

    always_comb begin
        cmd.raw_ins        = cfg.patch_enable && praw.ins;
        cmd.raw_ins_byte   = praw.ins_byte;
        cmd.raw_byte       = in_byte;
        cmd.guest_en       = to_guest;
        cmd.guest_ins      = cfg.patch_enable && to_guest && pguest.ins;
        cmd.guest_ins_byte = pguest.ins_byte;
        cmd.guest_chan     = chan_reg;
        cmd.guest_byte     = gdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg  <= 1'b0;
            chan_reg <= MAX_DEFAULT;
            cr_reg   <= '0;
            lf_reg   <= '0;
        end else if (push) begin
            esc_reg  <= esc_next;
            chan_reg <= chan_next;
            cr_reg   <= cr_next;
            lf_reg   <= lf_next;
        end
    end

endmodule

FILE: hw/rtl/etud_queue.sv
// Small command queue between front and back end.
module etud_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  etud_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output etud_pkg::cmd_t head
);
    import etud_pkg::*;

    cmd_t                slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_reg, wr_next;
    logic [Q_PTR_W-1:0]  rd_reg, rd_next;
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/etud_back.sv
// Back end: expands queued commands into output beats, one per cycle while the output is not stalled.
module etud_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  etud_pkg::cmd_t head,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [3:0]     m_tuser,
    output logic           m_tlast
);
    import etud_pkg::*;

    logic [1:0] ptr_reg, ptr_next;
    logic [3:0] slot_vld;
    logic [1:0] sel;
    logic       found;
    logic       is_last;
    logic       load;
    logic [7:0] sel_byte;
    logic [3:0] sel_chan;

    logic       vld_reg;
    logic [7:0] data_reg;
    logic [3:0] user_reg;
    logic       last_reg;

    // Slots in output order: raw insert, raw copy, guest insert, guest byte.
    assign slot_vld = {head.guest_en, head.guest_ins, 1'b1, head.raw_ins};

    always_comb begin
        found = 1'b0;
        sel   = 2'd1;
        for (int i = 0; i < 4; i++) begin
            if (!found && slot_vld[i] && 2'(i) >= ptr_reg) begin
                found = 1'b1;
                sel   = 2'(i);
            end
        end
        is_last = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (slot_vld[i] && 2'(i) > sel) begin
                is_last = 1'b0;
            end
        end
    end

    always_comb begin
        case (sel)
            2'd0:    begin sel_byte = head.raw_ins_byte;   sel_chan = RAW_CHANNEL; end
            2'd1:    begin sel_byte = head.raw_byte;       sel_chan = RAW_CHANNEL; end
            2'd2:    begin sel_byte = head.guest_ins_byte; sel_chan = head.guest_chan; end
            default: begin sel_byte = head.guest_byte;     sel_chan = head.guest_chan; end
        endcase
    end

    assign load     = !q_empty && (!vld_reg || m_tready);
    assign pop      = load && is_last;
    assign ptr_next = pop ? 2'd0 : (load ? sel + 2'd1 : ptr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= 2'd0;
            vld_reg <= 1'b0;
        end else begin
            ptr_reg <= ptr_next;
            if (load) begin
                vld_reg <= 1'b1;
            end else if (m_tready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= sel_byte;
            user_reg <= sel_chan;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: hw/rtl/escape_tagged_uart_demux.sv
// Escape-tagged UART byte demultiplexer, top level.
// Each received byte on the s_ side is copied to the raw channel 15, then
// decoded: the escape-start byte opens an escape, and the byte after it is
// either the escaped-escape code (a literal escape-start byte as data), the
// reset-select code (return to the default channel, 15 read as 14), one of
// the tag bytes E1..E8, EA..ED, EF, F0, E9 (channels 0..14), or ignored.
// Other bytes go to the current channel. With patch_enable set, each
// channel completes lone CR or LF with the missing partner, inserted in
// front of the next byte that is neither. The front end takes one byte per
// cycle while its 4-entry command queue has room; the back end emits the
// 1 to 4 beats of each byte at one beat per cycle while m_tready allows,
// through a registered master port. Each beat carries the channel on
// m_tuser and m_tlast marks the final beat caused by one input byte.
// Registers sit on an APB port at byte addresses 0x00..0x10; the user is to
// write them only while the block is idle, which the block does not enforce;
// writes do not disturb the decode state.
module escape_tagged_uart_demux (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic [3:0]                    m_tuser,   // [3:0] channel
    output logic                          m_tlast,   // last_of_run
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [etud_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import etud_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;
    logic     push, pop, q_full, q_empty;
    cmd_t     push_cmd, head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.escape_start_byte   <= 8'd0;
            cfg_reg.escaped_escape_byte <= 8'd0;
            cfg_reg.reset_select_byte   <= 8'd0;
            cfg_reg.patch_enable        <= 1'b0;
            cfg_reg.default_channel     <= MAX_DEFAULT;
        end else if (wr_en) begin
            unique case (idx)
                REG_ESC_START:  cfg_reg.escape_start_byte   <= pwdata[7:0];
                REG_ESC_ESC:    cfg_reg.escaped_escape_byte <= pwdata[7:0];
                REG_RESET_SEL:  cfg_reg.reset_select_byte   <= pwdata[7:0];
                REG_PATCH_EN:   cfg_reg.patch_enable        <= pwdata[0];
                REG_DEFAULT_CH: cfg_reg.default_channel     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ESC_START:  prdata = {24'd0, cfg_reg.escape_start_byte};
            REG_ESC_ESC:    prdata = {24'd0, cfg_reg.escaped_escape_byte};
            REG_RESET_SEL:  prdata = {24'd0, cfg_reg.reset_select_byte};
            REG_PATCH_EN:   prdata = {31'd0, cfg_reg.patch_enable};
            REG_DEFAULT_CH: prdata = {28'd0, cfg_reg.default_channel};
            default:        prdata = 32'd0;
        endcase
    end

    // Decode and patch state; pushes one command per accepted beat.
    etud_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .q_full   (q_full),
        .in_ready (s_tready),
        .push     (push),
        .cmd      (push_cmd)
    );

    etud_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    // Beat sequencer and output register.
    etud_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hw/rtl/etud_checker.sv
// Port-level checker for the escape-tagged UART demux, with its bind.
`include "escape_tagged_uart_demux_assert.svh"

module etud_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);

    `ETUD_ASSERT(a_hold_valid, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "stalled beat dropped")
    `ETUD_ASSERT(a_hold_data, aclk, aresetn, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled beat changed")
    `ETUD_ASSERT(a_run_no_gap, aclk, aresetn, (m_tvalid && m_tready && !m_tlast) |=> m_tvalid, "gap inside a run")
    `ETUD_ASSERT_ANY(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind escape_tagged_uart_demux etud_checker u_etud_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: tb/escape_tagged_uart_demux_tb.sv
// Self-checking testbench for the escape-tagged UART byte demultiplexer.
module escape_tagged_uart_demux_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import etud_pkg::*;

    localparam logic [3:0] RAW_CH       = 4'd15;
    localparam logic [3:0] TOP_GUEST_CH = 4'd14;
    localparam logic [7:0] LF_BYTE      = 8'h0a;
    localparam logic [7:0] CR_BYTE      = 8'h0d;
    localparam logic [2:0] REG_UNUSED   = 3'd5;    // no register here, writes are dropped
    localparam int         TAGS_USED    = (TAG_COUNT < 15) ? TAG_COUNT : 15;
    localparam int         QUIET_LIMIT  = 2000;    // cycles without any beat or bus write
    localparam int         SQUEEZE_LEN  = 300;     // long receiver hold-off
    localparam int         SETTLE_CYC   = 8;       // block latency margin between phases

    // tag byte -> guest channel, index is the channel
    localparam logic [7:0] GUEST_TAGS [15] = '{
        8'he1, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8,
        8'hea, 8'heb, 8'hec, 8'hed, 8'hef, 8'hf0, 8'he9
    };

    typedef struct {
        logic [3:0] chan;
        logic [7:0] data;
        logic       last_flag;
    } beat_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] out_byte
    logic [3:0]  m_tuser;            // [3:0] channel
    logic        m_tlast;            // last_of_run
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    escape_tagged_uart_demux dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: shadow config and decode state, filled beats go to
    // beats_due in output order
    // ------------------------------------------------------------------
    logic [7:0] esc_start_code = 8'h00;
    logic [7:0] esc_esc_code   = 8'h00;
    logic [7:0] reset_code     = 8'h00;
    logic       patch_on       = 1'b0;
    logic [3:0] dflt_ch        = 4'd14;

    logic        esc_open = 1'b0;
    logic [3:0]  cur_ch   = 4'd14;
    logic [15:0] cr_seen  = '0;
    logic [15:0] lf_seen  = '0;

    beat_t       beats_due [$];
    logic [7:0]  rx_pending [$];
    int          fault_cnt = 0;

    function automatic void due_push(logic [3:0] chan, logic [7:0] b);
        beat_t bt;
        bt.chan      = chan;
        bt.data      = b;
        bt.last_flag = 1'b0;
        beats_due.push_back(bt);
    endfunction

    // one byte onto one channel, with CR/LF pair completion when enabled
    function automatic void emit_patched(logic [3:0] chan, logic [7:0] b);
        if (!patch_on) begin
            due_push(chan, b);
            return;
        end
        if (b == LF_BYTE) begin
            lf_seen[chan] = 1'b1;
        end else if (b == CR_BYTE) begin
            cr_seen[chan] = 1'b1;
        end else begin
            // lone CR gets its LF first; a lone LF gets its CR
            if (cr_seen[chan]) begin
                due_push(chan, LF_BYTE);
                cr_seen[chan] = 1'b0;
                lf_seen[chan] = 1'b0;
            end
            if (lf_seen[chan]) begin
                due_push(chan, CR_BYTE);
                cr_seen[chan] = 1'b0;
                lf_seen[chan] = 1'b0;
            end
        end
        due_push(chan, b);
        // a full pair needs no completion
        if (cr_seen[chan] && lf_seen[chan]) begin
            cr_seen[chan] = 1'b0;
            lf_seen[chan] = 1'b0;
        end
    endfunction

    function automatic void demux_predict(logic [7:0] b);
        logic [7:0] data;
        logic       to_guest;
        logic       hit;
        int         i;
        data     = b;
        to_guest = 1'b0;
        hit      = 1'b0;
        emit_patched(RAW_CH, b);    // raw copy always comes first
        if (esc_open) begin
            esc_open = 1'b0;
            // priority: escaped escape, then reset select, then tag table
            if (b == esc_esc_code) begin
                data     = esc_start_code;
                to_guest = 1'b1;
            end else if (b == reset_code) begin
                cur_ch = (dflt_ch == RAW_CH) ? TOP_GUEST_CH : dflt_ch;
            end else begin
                for (i = 0; i < TAGS_USED; i++) begin
                    if (!hit && b == GUEST_TAGS[i]) begin
                        cur_ch = i[3:0];
                        hit    = 1'b1;
                    end
                end
            end
        end else if (b == esc_start_code) begin
            esc_open = 1'b1;
        end else begin
            to_guest = 1'b1;
        end
        if (to_guest)
            emit_patched(cur_ch, data);
        beats_due[beats_due.size()-1].last_flag = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: pops rx_pending, holds a beat until it is taken
    // ------------------------------------------------------------------
    int   send_idle_pct = 0;
    logic s_beat_done   = 1'b0;

    always @(posedge aclk) begin
        s_beat_done <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            demux_predict(s_tdata);
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_beat_done) begin
            if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_pending.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off so the command
    // queue fills and s_tready drops
    // ------------------------------------------------------------------
    int   stall_pct   = 0;
    logic squeeze_on  = 1'b0;
    int   squeeze_cnt = 0;

    always @(negedge aclk) begin
        if (squeeze_on && squeeze_cnt < SQUEEZE_LEN) begin
            m_tready    <= 1'b0;
            squeeze_cnt <= squeeze_cnt + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: each output beat against the oldest prediction
    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (beats_due.size() == 0) begin
                $display("%0t ns: unexpected beat, expected none, actual ch=%0d byte=%h last=%b",
                         $time, m_tuser, m_tdata, m_tlast);
                fault_cnt++;
            end else begin
                want = beats_due.pop_front();
                if (m_tuser !== want.chan || m_tdata !== want.data
                        || m_tlast !== want.last_flag) begin
                    $display("%0t ns: beat mismatch, expected ch=%0d byte=%h last=%b, actual ch=%0d byte=%h last=%b",
                             $time, want.chan, want.data, want.last_flag,
                             m_tuser, m_tdata, m_tlast);
                    fault_cnt++;
                end
            end
        end
    end

    // watchdog: too long with no beat on either side and no bus access
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Register access; shadow copy follows at the write edge
    // ------------------------------------------------------------------
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_ESC_START:  esc_start_code = val[7:0];
            REG_ESC_ESC:    esc_esc_code   = val[7:0];
            REG_RESET_SEL:  reset_code     = val[7:0];
            REG_PATCH_EN:   patch_on       = val[0];
            REG_DEFAULT_CH: dflt_ch        = val[3:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] start_b, logic [7:0] esc_b, logic [7:0] rst_b,
                              logic patch, logic [3:0] dch);
        reg_write(REG_ESC_START, {24'h0, start_b});
        reg_write(REG_ESC_ESC, {24'h0, esc_b});
        reg_write(REG_RESET_SEL, {24'h0, rst_b});
        reg_write(REG_PATCH_EN, {31'h0, patch});
        reg_write(REG_DEFAULT_CH, {28'h0, dch});
    endtask

    // wait until every byte went in and every beat came out, then settle
    task automatic drain();
        while (rx_pending.size() != 0 || s_tvalid || beats_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_idle(int profile);
        case (profile)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 83; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
        endcase
    endtask

    function automatic logic [7:0] text_byte();
        case ($urandom_range(9))
            0: return CR_BYTE;
            1: return LF_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly well-formed escape sequences with random payload, some noise
    task automatic queue_traffic(int n);
        int made;
        int pick;
        int k;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                rx_pending.push_back(text_byte());
                made += 1;
            end else if (pick < 50) begin
                rx_pending.push_back(esc_start_code);
                case ($urandom_range(5))
                    0: rx_pending.push_back(8'hee);   // gap in the tag table
                    1: rx_pending.push_back(8'hf1);
                    default: rx_pending.push_back(GUEST_TAGS[$urandom_range(TAGS_USED-1)]);
                endcase
                made += 2;
            end else if (pick < 60) begin
                rx_pending.push_back(esc_start_code);
                rx_pending.push_back(reset_code);
                made += 2;
            end else if (pick < 70) begin
                rx_pending.push_back(esc_start_code);
                rx_pending.push_back(esc_esc_code);
                made += 2;
            end else if (pick < 78) begin
                rx_pending.push_back(esc_start_code);
                rx_pending.push_back(8'($urandom_range(255)));
                made += 2;
            end else if (pick < 92) begin
                // CR/LF run, then a byte that flushes any completion
                for (k = 0; k <= $urandom_range(2); k++) begin
                    rx_pending.push_back($urandom_range(1) ? CR_BYTE : LF_BYTE);
                    made += 1;
                end
                rx_pending.push_back(8'($urandom_range(255)));
                made += 1;
            end else begin
                rx_pending.push_back(8'($urandom_range(255)));
                made += 1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int ph;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        set_idle(0);

        // reset config: escape, escaped escape and reset select all 0x00,
        // so the escaped-escape code wins over the reset code
        rx_pending = '{8'h41, 8'h00, 8'he1, 8'h42, 8'h00, 8'h00, 8'h00, 8'hf0,
                       8'h00, 8'h55, 8'h80};
        drain();

        // reset code collides with tag E1, default 15 must act as 14,
        // patch on; plus a write to an unused address
        set_config(8'hff, 8'hfe, 8'he1, 1'b1, 4'd15);
        reg_write(REG_UNUSED, 32'hffff_ffff);
        rx_pending = '{8'hff, 8'he2,                // channel 1
                       8'h0d, 8'h41,                // lone CR -> LF inserted
                       8'h0a, 8'h42,                // lone LF -> CR inserted
                       8'h0d, 8'h0a, 8'h43,         // full pair, nothing inserted
                       8'hff, 8'he1,                // reset select beats the tag
                       8'hff, 8'hfe,                // literal 0xFF
                       8'h44};
        drain();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(8'h1b, 8'h5c, 8'h2a, 1'b1, 4'd3);
                1: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 1'b1, 4'($urandom_range(15)));
                2: set_config(8'hff, 8'h00, 8'hff, 1'b0, 4'd0);
                3: set_config(8'h7e, 8'h5e, 8'he5, 1'b1, 4'd15);
                4: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 1'($urandom_range(1)),
                              4'($urandom_range(15)));
                default: set_config(8'h00, 8'hff, 8'h00, 1'b1, 4'd14);
            endcase
            set_idle(ph % 4);
            queue_traffic(50);
            if (ph == 0)
                squeeze_on = 1'b1;    // sender keeps offering through the hold-off
            drain();
        end

        repeat (16) @(posedge aclk);
        if (fault_cnt == 0 && beats_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
